// ===== src/lbps_pkg.sv =====
// shared types, constants and pattern tables for the led bar pattern sequencer
package lbps_pkg;

   // pattern codes are ascii '0'..'7' (0x30..0x37)
   localparam logic [4:0] CODE_PREFIX = 5'b00110;

   localparam logic [7:0] ALT_START   = 8'hAA;
   localparam logic [7:0] FIXED_LED   = 8'hAA;
   localparam logic [7:0] UP_START    = 8'h00;
   localparam logic [7:0] DOWN_START  = 8'h00;
   localparam logic [7:0] DOWN_RESET  = 8'hFF;
   localparam logic [2:0] BOUNCE_LAST = 3'd5;
   localparam logic [7:0] WALK_ONE_LSB  = 8'h01;
   localparam logic [7:0] WALK_ZERO_MSB = 8'h80;
   localparam logic [7:0] BASE_PERIOD_RESET = 8'd16;

   localparam logic [2:0] MULT_X1 = 3'd1;
   localparam logic [2:0] MULT_X2 = 3'd2;
   localparam logic [2:0] MULT_X4 = 3'd4;
   localparam logic [2:0] MULT_X6 = 3'd6;

   typedef enum logic [2:0] {
      PAT_FIXED,
      PAT_ALT,
      PAT_UP,
      PAT_BOUNCE,
      PAT_DOWN,
      PAT_WALK_ONE,
      PAT_WALK_ZERO,
      PAT_FILL
   } pattern_type;

   // one accepted input item
   typedef struct packed {
      logic [7:0] pattern_code;
      logic       restart;
   } item_type;

   // one result item
   typedef struct packed {
      logic [7:0]  led_byte;
      logic [2:0]  multiplier;
      logic [10:0] hold_ticks;
      logic        restart_taken;
   } result_type;

   // bouncing pair, indices 6 and 7 are unreachable
   function automatic logic [7:0] bounce_led(input logic [2:0] idx);
      logic [7:0] led;
      unique case (idx)
         3'd0:    led = 8'h18;
         3'd1:    led = 8'h24;
         3'd2:    led = 8'h42;
         3'd3:    led = 8'h81;
         3'd4:    led = 8'h42;
         3'd5:    led = 8'h24;
         default: led = 8'h18;
      endcase
      return led;
   endfunction

   // thermometer fill from the right
   function automatic logic [7:0] fill_led(input logic [2:0] idx);
      logic [7:0] led;
      unique case (idx)
         3'd0:    led = 8'h01;
         3'd1:    led = 8'h03;
         3'd2:    led = 8'h07;
         3'd3:    led = 8'h0F;
         3'd4:    led = 8'h1F;
         3'd5:    led = 8'h3F;
         3'd6:    led = 8'h7F;
         default: led = 8'hFF;
      endcase
      return led;
   endfunction

endpackage

// ===== src/lbps_req_stage.sv =====
// input register stage for pattern transition requests
module lbps_req_stage
   import lbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_pattern_code,
   input  logic       req_restart,
   input  logic       take,
   output logic       item_valid,
   output item_type   item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // stall only while a held item is not taken this cycle
   assign req_stall = valid_ff && !take;
   assign valid_in  = req_valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= valid_in;
      end
   end

   // payload loads on every transfer
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.pattern_code <= req_pattern_code;
         item_ff.restart      <= req_restart;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/lbps_pattern_core.sv =====
// per-pattern position state and next led value computation
module lbps_pattern_core
   import lbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   input  logic [7:0] base_period,
   input  logic       rsp_free,
   output logic       take,
   output logic       load,
   output result_type result
);

   logic [7:0] alt_value_ff, alt_value_in;
   logic [7:0] up_count_ff, up_count_in;
   logic [2:0] bounce_index_ff, bounce_index_in;
   logic [7:0] down_count_ff, down_count_in;
   logic [2:0] walk_one_index_ff, walk_one_index_in;
   logic [2:0] walk_zero_index_ff, walk_zero_index_in;
   logic [2:0] fill_index_ff, fill_index_in;

   logic        code_ok;
   pattern_type pattern;
   logic [7:0]  led;
   logic [2:0]  mult;

   // decode and handshake: unknown codes are dropped without a result
   assign code_ok = (item.pattern_code[7:3] == CODE_PREFIX);
   assign pattern = pattern_type'(item.pattern_code[2:0]);
   assign load    = item_valid && code_ok && rsp_free;
   assign take    = item_valid && (!code_ok || rsp_free);

   // next position of the selected pattern and its led value
   always_comb begin
      alt_value_in       = alt_value_ff;
      up_count_in        = up_count_ff;
      bounce_index_in    = bounce_index_ff;
      down_count_in      = down_count_ff;
      walk_one_index_in  = walk_one_index_ff;
      walk_zero_index_in = walk_zero_index_ff;
      fill_index_in      = fill_index_ff;
      led                = FIXED_LED;
      mult               = MULT_X1;
      unique case (pattern)
         PAT_FIXED: begin
            mult = MULT_X1;
            led  = FIXED_LED;
         end
         PAT_ALT: begin
            mult         = MULT_X4;
            alt_value_in = item.restart ? ALT_START : ~alt_value_ff;
            led          = alt_value_in;
         end
         PAT_UP: begin
            mult        = MULT_X2;
            up_count_in = item.restart ? UP_START : up_count_ff + 8'd1;
            led         = up_count_in;
         end
         PAT_BOUNCE: begin
            mult = MULT_X2;
            if (item.restart || bounce_index_ff >= BOUNCE_LAST) begin
               bounce_index_in = 3'd0;
            end else begin
               bounce_index_in = bounce_index_ff + 3'd1;
            end
            led = bounce_led(bounce_index_in);
         end
         PAT_DOWN: begin
            mult          = MULT_X1;
            down_count_in = item.restart ? DOWN_START : down_count_ff - 8'd1;
            led           = down_count_in;
         end
         PAT_WALK_ONE: begin
            mult              = MULT_X6;
            walk_one_index_in = item.restart ? 3'd0 : walk_one_index_ff + 3'd1;
            led               = WALK_ONE_LSB << walk_one_index_in;
         end
         PAT_WALK_ZERO: begin
            mult               = MULT_X2;
            walk_zero_index_in = item.restart ? 3'd0 : walk_zero_index_ff + 3'd1;
            led                = ~(WALK_ZERO_MSB >> walk_zero_index_in);
         end
         PAT_FILL: begin
            mult          = MULT_X4;
            fill_index_in = item.restart ? 3'd0 : fill_index_ff + 3'd1;
            led           = fill_led(fill_index_in);
         end
         default: begin
            mult = MULT_X1;
            led  = FIXED_LED;
         end
      endcase
   end

   // position state moves only when a result is produced
   always_ff @(posedge clock) begin
      if (reset) begin
         alt_value_ff       <= ALT_START;
         up_count_ff        <= UP_START;
         bounce_index_ff    <= 3'd0;
         down_count_ff      <= DOWN_RESET;
         walk_one_index_ff  <= 3'd0;
         walk_zero_index_ff <= 3'd0;
         fill_index_ff      <= 3'd0;
      end else if (load) begin
         alt_value_ff       <= alt_value_in;
         up_count_ff        <= up_count_in;
         bounce_index_ff    <= bounce_index_in;
         down_count_ff      <= down_count_in;
         walk_one_index_ff  <= walk_one_index_in;
         walk_zero_index_ff <= walk_zero_index_in;
         fill_index_ff      <= fill_index_in;
      end
   end

   // result fields, hold time is a small 8 by 3 product
   assign result.led_byte      = led;
   assign result.multiplier    = mult;
   assign result.hold_ticks    = 11'(base_period) * 11'(mult);
   assign result.restart_taken = item.restart;

endmodule

// ===== src/lbps_rsp_stage.sv =====
// result register stage for led bar results
module lbps_rsp_stage
   import lbps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   output logic        rsp_free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_led_byte,
   output logic [2:0]  rsp_multiplier,
   output logic [10:0] rsp_hold_ticks,
   output logic        rsp_restart_taken
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // register can take a new result when empty or its transfer completes
   assign rsp_free = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_led_byte      = result_ff.led_byte;
   assign rsp_multiplier    = result_ff.multiplier;
   assign rsp_hold_ticks    = result_ff.hold_ticks;
   assign rsp_restart_taken = result_ff.restart_taken;

endmodule

// ===== src/led_bar_pattern_sequencer.sv =====
// top level of the led bar pattern sequencer
// Each request ('0'..'7' in req_pattern_code) advances or restarts one of
// eight led bar patterns, each but the fixed one keeping its own position,
// and yields one result with the led byte, the period multiplier and the
// hold time (base_period times multiplier); any other code is consumed with
// no result and no state change. The block takes one request every clock
// cycle while req_stall is low: a request passes the input register, the
// pattern logic and the result register, and its result is presented on the
// rsp ports from the result register. The user must write base_period
// through the csr port only while the block is idle; the block itself does
// not enforce this.
module led_bar_pattern_sequencer
   import lbps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pattern_code,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_led_byte,
   output logic [2:0]  rsp_multiplier,
   output logic [10:0] rsp_hold_ticks,
   output logic        rsp_restart_taken
);

   logic [7:0] base_period_ff;
   logic       item_valid;
   item_type   item;
   logic       take;
   logic       load;
   logic       rsp_free;
   result_type result;

   // base period register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_period_ff <= BASE_PERIOD_RESET;
      end else if (csr_wr_en) begin
         base_period_ff <= csr_wr_data;
      end
   end

   lbps_req_stage u_req_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pattern_code (req_pattern_code),
      .req_restart      (req_restart),
      .take             (take),
      .item_valid       (item_valid),
      .item             (item)
   );

   lbps_pattern_core u_pattern_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .base_period (base_period_ff),
      .rsp_free    (rsp_free),
      .take        (take),
      .load        (load),
      .result      (result)
   );

   lbps_rsp_stage u_rsp_stage (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .result            (result),
      .rsp_free          (rsp_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_led_byte      (rsp_led_byte),
      .rsp_multiplier    (rsp_multiplier),
      .rsp_hold_ticks    (rsp_hold_ticks),
      .rsp_restart_taken (rsp_restart_taken)
   );

endmodule
